// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, quiet while reset is high.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/rbwd_pkg.sv =====
package rbwd_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int THRESH_W   = 6;
   localparam int MODE_W     = 3;
   localparam int XC_W       = 4;
   localparam int GSUM_OUT_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int WINDOW_DEPTH_DEF = 8;

   // Distance override and crossing tracker constants.
   localparam int unsigned DIST_SUM_LIMIT = 5;
   localparam int unsigned OVR_LEFT_SUM   = 2;
   localparam int unsigned OVR_RIGHT_SUM  = 1;
   localparam int unsigned GSUM_SAT       = 63;
   localparam logic [XC_W-1:0] XC_STATE_A = 4'b0100;
   localparam logic [XC_W-1:0] XC_STATE_B = 4'b0010;

   // Register reset values.
   localparam logic [SAMPLE_W-1:0] GRAY_LOW_RST      = 12'd1500;
   localparam logic [SAMPLE_W-1:0] GRAY_HIGH_RST     = 12'd2500;
   localparam logic [THRESH_W-1:0] LINE_THRESH_RST   = 6'd6;
   localparam logic [SAMPLE_W-1:0] MIRROR_FLOOR_RST  = 12'd0;
   localparam logic [SAMPLE_W-1:0] MIRROR_CEIL_RST   = 12'd400;
   localparam logic [THRESH_W-1:0] MIRROR_THRESH_RST = 6'd4;
   localparam logic [MODE_W-1:0]   TARGET_MODE_RST   = 3'd0;
   localparam logic [SAMPLE_W-1:0] BRIGHT_LIMIT_RST  = 12'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAY_LOW      = 3'd0,
      CSR_GRAY_HIGH     = 3'd1,
      CSR_LINE_THRESH   = 3'd2,
      CSR_MIRROR_FLOOR  = 3'd3,
      CSR_MIRROR_CEIL   = 3'd4,
      CSR_MIRROR_THRESH = 3'd5,
      CSR_TARGET_MODE   = 3'd6,
      CSR_BRIGHT_LIMIT  = 3'd7
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE       = 3'd0,
      MODE_ALL_DARK   = 3'd1,
      MODE_LEFT_DARK  = 3'd2,
      MODE_RIGHT_DARK = 3'd3,
      MODE_MIRROR     = 3'd4
   } mode_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] gray_low;
      logic [SAMPLE_W-1:0] gray_high;
      logic [THRESH_W-1:0] line_thresh;
      logic [SAMPLE_W-1:0] mirror_floor;
      logic [SAMPLE_W-1:0] mirror_ceil;
      logic [THRESH_W-1:0] mirror_thresh;
      logic [MODE_W-1:0]   target_mode;
      logic [SAMPLE_W-1:0] bright_limit;
   } cfg_type;

   // Count of the two samples that lie strictly between lo and hi.
   function automatic logic [1:0] pair_in_band(logic [SAMPLE_W-1:0] v0,
                                               logic [SAMPLE_W-1:0] v1,
                                               logic [SAMPLE_W-1:0] lo,
                                               logic [SAMPLE_W-1:0] hi);
      logic b0;
      logic b1;
      b0 = (v0 > lo) && (v0 < hi);
      b1 = (v1 > lo) && (v1 < hi);
      return {1'b0, b0} + {1'b0, b1};
   endfunction

endpackage

// ===== hw/rtl/rbwd_req_if.sv =====
interface rbwd_req_if import rbwd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_a;
   logic [SAMPLE_W-1:0] sample_b;
   logic [SAMPLE_W-1:0] sample_c;
   logic [SAMPLE_W-1:0] sample_d;
   logic [SAMPLE_W-1:0] sample_e;
   logic [SAMPLE_W-1:0] sample_f;
   logic                detect_pending;
   logic                actuation_busy;
   logic                distance_near;
   logic                at_intersection;
   logic [XC_W-1:0]     crossing_state;

   modport source (output valid, sample_a, sample_b, sample_c, sample_d, sample_e,
                   sample_f, detect_pending, actuation_busy, distance_near,
                   at_intersection, crossing_state, input ready);
   modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, sample_e,
                   sample_f, detect_pending, actuation_busy, distance_near,
                   at_intersection, crossing_state, output ready);
endinterface

// ===== hw/rtl/rbwd_rsp_if.sv =====
interface rbwd_rsp_if import rbwd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  line_found;
   logic                  target_found;
   logic                  mirror_found;
   logic [GSUM_OUT_W-1:0] gray_window_sum;

   modport source (output valid, line_found, target_found, mirror_found,
                   gray_window_sum, input ready);
   modport sink   (input valid, line_found, target_found, mirror_found,
                   gray_window_sum, output ready);
endinterface

// ===== hw/rtl/rbwd_ring.sv =====
// History line of 2-bit counts with a running sum that includes the entry
// being pushed in this cycle.
module rbwd_ring #(
   parameter int DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift_en,
   input  logic                              clear,
   input  logic [1:0]                        din,
   output logic [$clog2(2*DEPTH+1)-1:0]      sum
);

   localparam int SUM_W = $clog2(2*DEPTH+1);

   logic [1:0]       tap_ff [DEPTH];
   logic [1:0]       tap_in [DEPTH];
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   // The oldest entry leaves as the new one enters.
   assign sum = sum_ff + SUM_W'(din) - SUM_W'(tap_ff[DEPTH-1]);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (clear) begin
            tap_in[i] = 2'd0;
         end else if (i == 0) begin
            tap_in[i] = din;
         end else begin
            tap_in[i] = tap_ff[i-1];
         end
      end
      sum_in = clear ? '0 : sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tap_ff[i] <= 2'd0;
         end
         sum_ff <= '0;
      end else if (shift_en) begin
         tap_ff <= tap_in;
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== hw/rtl/rbwd_csr.sv =====
// Configuration register file, write only.
module rbwd_csr import rbwd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  index,
   input  logic [CSR_DATA_W-1:0] wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gray_low      <= GRAY_LOW_RST;
         cfg_ff.gray_high     <= GRAY_HIGH_RST;
         cfg_ff.line_thresh   <= LINE_THRESH_RST;
         cfg_ff.mirror_floor  <= MIRROR_FLOOR_RST;
         cfg_ff.mirror_ceil   <= MIRROR_CEIL_RST;
         cfg_ff.mirror_thresh <= MIRROR_THRESH_RST;
         cfg_ff.target_mode   <= TARGET_MODE_RST;
         cfg_ff.bright_limit  <= BRIGHT_LIMIT_RST;
      end else if (wr_en) begin
         unique case (index)
            CSR_GRAY_LOW:      cfg_ff.gray_low      <= wdata[SAMPLE_W-1:0];
            CSR_GRAY_HIGH:     cfg_ff.gray_high     <= wdata[SAMPLE_W-1:0];
            CSR_LINE_THRESH:   cfg_ff.line_thresh   <= wdata[THRESH_W-1:0];
            CSR_MIRROR_FLOOR:  cfg_ff.mirror_floor  <= wdata[SAMPLE_W-1:0];
            CSR_MIRROR_CEIL:   cfg_ff.mirror_ceil   <= wdata[SAMPLE_W-1:0];
            CSR_MIRROR_THRESH: cfg_ff.mirror_thresh <= wdata[THRESH_W-1:0];
            CSR_TARGET_MODE:   cfg_ff.target_mode   <= wdata[MODE_W-1:0];
            CSR_BRIGHT_LIMIT:  cfg_ff.bright_limit  <= wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== hw/rtl/reflectance_band_window_detector_core.sv =====
// Reflectance band window detector. Each request carries one frame of six
// reflectance samples and the robot status flags, and produces exactly one
// response: line_found, target_found, mirror_found and the gray window sum.
// A request is taken every clock cycle when the response side keeps up; a
// frame is registered in the input register on acceptance, and its response
// is registered in the result register when that frame moves on. A response
// that is not taken holds the frame behind it in the input register, and the
// request side stalls only when both are occupied. The single pass per frame
// is possible because each history window keeps a running sum that is
// updated with the entering and leaving entry instead of being re-added over
// the whole window. Configuration is written through the csr_ port; it must
// be written only while no request is in flight, which the block itself does
// not enforce. Writes take effect at once.
module reflectance_band_window_detector_core import rbwd_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rbwd_req_if.sink              req_ch,
   rbwd_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Width of one side's window sum, of the left plus right total, and a
   // compare width wide enough for the total and the 6-bit thresholds.
   localparam int LSUM_W  = $clog2(2*WINDOW_DEPTH+1);
   localparam int TOT_W   = LSUM_W + 1;
   localparam int CMP_W   = (TOT_W > THRESH_W) ? TOT_W : THRESH_W;
   localparam int MCMP_W  = (LSUM_W > THRESH_W) ? LSUM_W : THRESH_W;

   cfg_type cfg;

   rbwd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   // Input register stage.
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [SAMPLE_W-1:0] sa_ff, sb_ff, sc_ff, sd_ff, se_ff, sf_ff;
   logic                pending_ff, busy_ff, near_ff, inter_ff;
   logic [XC_W-1:0]     xc_ff;

   // Result register stage.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  line_ff, target_ff, mirror_ff;
   logic [GSUM_OUT_W-1:0] gsum_ff;

   logic req_take;
   logic advance;

   // The frame in the input register moves on whenever the result register is
   // empty or its response is being taken in this same cycle.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sa_ff      <= req_ch.sample_a;
         sb_ff      <= req_ch.sample_b;
         sc_ff      <= req_ch.sample_c;
         sd_ff      <= req_ch.sample_d;
         se_ff      <= req_ch.sample_e;
         sf_ff      <= req_ch.sample_f;
         pending_ff <= req_ch.detect_pending;
         busy_ff    <= req_ch.actuation_busy;
         near_ff    <= req_ch.distance_near;
         inter_ff   <= req_ch.at_intersection;
         xc_ff      <= req_ch.crossing_state;
      end
   end

   // Per-frame band counts: left pair is d and f, right pair is c and e.
   logic [1:0] gray_left_cnt;
   logic [1:0] gray_right_cnt;
   logic [1:0] mirror_cnt;

   assign gray_left_cnt  = pair_in_band(sd_ff, sf_ff, cfg.gray_low, cfg.gray_high);
   assign gray_right_cnt = pair_in_band(sc_ff, se_ff, cfg.gray_low, cfg.gray_high);
   assign mirror_cnt     = pair_in_band(sc_ff, se_ff, cfg.mirror_floor, cfg.mirror_ceil);

   logic              mode_mirror;
   logic              mirror_shift;
   logic              line_hit;
   logic              mirror_hit;
   logic              target_hit;
   logic [LSUM_W-1:0] lsum, rsum, msum;

   assign mode_mirror  = (cfg.target_mode == MODE_MIRROR);
   // The mirror window only records frames seen in mirror mode.
   assign mirror_shift = advance && mode_mirror;

   rbwd_ring #(.DEPTH(WINDOW_DEPTH)) u_left_ring (
      .clock    (clock),
      .reset    (reset),
      .shift_en (advance),
      .clear    (line_hit),
      .din      (gray_left_cnt),
      .sum      (lsum)
   );

   rbwd_ring #(.DEPTH(WINDOW_DEPTH)) u_right_ring (
      .clock    (clock),
      .reset    (reset),
      .shift_en (advance),
      .clear    (line_hit),
      .din      (gray_right_cnt),
      .sum      (rsum)
   );

   rbwd_ring #(.DEPTH(WINDOW_DEPTH)) u_mirror_ring (
      .clock    (clock),
      .reset    (reset),
      .shift_en (mirror_shift),
      .clear    (mirror_hit),
      .din      (mirror_cnt),
      .sum      (msum)
   );

   // Gray total with the distance override: near the obstacle a large total
   // is replaced by a fixed left and right contribution.
   logic [TOT_W-1:0] raw_total;
   logic [TOT_W-1:0] gray_total;
   logic [CMP_W-1:0] gray_total_cmp;

   assign raw_total = TOT_W'(lsum) + TOT_W'(rsum);

   always_comb begin
      if (near_ff && (raw_total > TOT_W'(DIST_SUM_LIMIT))) begin
         gray_total = TOT_W'(OVR_LEFT_SUM) + TOT_W'(OVR_RIGHT_SUM);
      end else begin
         gray_total = raw_total;
      end
   end

   assign gray_total_cmp = CMP_W'(gray_total);

   // A line is reported only when nothing else holds a detection; the gray
   // windows are then cleared.
   assign line_hit = !pending_ff && !busy_ff &&
                     (gray_total_cmp > CMP_W'(cfg.line_thresh));

   logic [GSUM_OUT_W-1:0] gsum_sat;

   assign gsum_sat = (gray_total_cmp > CMP_W'(GSUM_SAT)) ? GSUM_OUT_W'(GSUM_SAT)
                                                         : gray_total_cmp[GSUM_OUT_W-1:0];

   // Dark pattern checks. Sensors a to d must all be dark; e and f decide the
   // pattern. Side patterns need one sensor clearly bright.
   logic dark_abcd;
   logic dark_e, dark_f;
   logic bright_e, bright_f;
   logic xc_ok;

   assign dark_abcd = (sa_ff > cfg.gray_high) && (sb_ff > cfg.gray_high) &&
                      (sc_ff > cfg.gray_high) && (sd_ff > cfg.gray_high);
   assign dark_e    = se_ff > cfg.gray_high;
   assign dark_f    = sf_ff > cfg.gray_high;
   assign bright_e  = se_ff < cfg.bright_limit;
   assign bright_f  = sf_ff < cfg.bright_limit;
   assign xc_ok     = (xc_ff == XC_STATE_A) || (xc_ff == XC_STATE_B);

   // Mirror detection compares the window against half the threshold.
   logic [THRESH_W-1:0] mirror_half;

   assign mirror_half = cfg.mirror_thresh >> 1;

   always_comb begin
      target_hit = 1'b0;
      mirror_hit = 1'b0;
      unique case (cfg.target_mode)
         MODE_ALL_DARK:   target_hit = dark_abcd && dark_e && dark_f && xc_ok;
         MODE_LEFT_DARK:  target_hit = dark_abcd && bright_e && dark_f && !inter_ff;
         MODE_RIGHT_DARK: target_hit = dark_abcd && dark_e && bright_f && !inter_ff;
         MODE_MIRROR:     mirror_hit = (MCMP_W'(msum) > MCMP_W'(mirror_half)) && !inter_ff;
         // No pattern check, also for the unused mode codes.
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         line_ff   <= line_hit;
         target_ff <= target_hit;
         mirror_ff <= mirror_hit;
         gsum_ff   <= gsum_sat;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.line_found      = line_ff;
   assign rsp_ch.target_found    = target_ff;
   assign rsp_ch.mirror_found    = mirror_ff;
   assign rsp_ch.gray_window_sum = gsum_ff;

endmodule

// ===== hw/rtl/rbwd_checker.sv =====
`include "assert_macros.svh"

// Port-level checks on the detector core.
module rbwd_checker import rbwd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  line_found,
   input logic                  target_found,
   input logic                  mirror_found,
   input logic [GSUM_OUT_W-1:0] gray_window_sum
);

   logic [GSUM_OUT_W+2:0] rsp_fields;

   assign rsp_fields = {line_found, target_found, mirror_found, gray_window_sum};

   // A stalled response stays up with its fields held.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_fields))

   // Reset empties the result register.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // A reported line always comes with a nonzero window sum.
   `ASSERT_IMPLIES(a_line_sum, clock, reset, rsp_valid && line_found, gray_window_sum != '0)

   // The dark pattern modes and the mirror mode exclude each other.
   `ASSERT_IMPLIES(a_mode_excl, clock, reset, rsp_valid && mirror_found, !target_found)

endmodule

bind reflectance_band_window_detector_core rbwd_checker u_rbwd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .line_found      (rsp_ch.line_found),
   .target_found    (rsp_ch.target_found),
   .mirror_found    (rsp_ch.mirror_found),
   .gray_window_sum (rsp_ch.gray_window_sum)
);
